// ===== src/z80_bank_memory_mapper_defines.svh =====
// Assertion macros for the Z80 bank memory mapper.
// Depends on nothing; included by the files that assert.
`ifndef Z80_BANK_MEMORY_MAPPER_DEFINES_SVH
`define Z80_BANK_MEMORY_MAPPER_DEFINES_SVH

// Condition must hold in the same cycle as its trigger.
`define ZBM_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition must hold in the cycle after its trigger.
`define ZBM_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== src/zbm_pkg.sv =====
// Types and constants shared by the Z80 bank memory mapper modules.
// Depends on nothing.
package zbm_pkg;

    // Default number of RAM pages fitted.
    localparam int RAM_PAGES_DEFAULT = 8;

    // Command codes.
    localparam logic [1:0] CMD_PORT_WRITE = 2'd0;
    localparam logic [1:0] CMD_PORT_READ  = 2'd1;
    localparam logic [1:0] CMD_SET_MODE   = 2'd2;
    localparam logic [1:0] CMD_ACCESS     = 2'd3;

    // I/O port numbers of the bank registers.
    localparam logic [7:0] PORT_RAM_BANK = 8'h05;
    localparam logic [7:0] PORT_BANK_A   = 8'h06;
    localparam logic [7:0] PORT_BANK_B   = 8'h07;
    localparam logic [7:0] PORT_BANK_A_H = 8'h0e;
    localparam logic [7:0] PORT_BANK_B_H = 8'h0f;

    // Bank byte values and boot pages.
    localparam logic [7:0] RAM_SELECT     = 8'h80;
    localparam logic [7:0] BOOT_PAGE_SM   = 8'h7f;
    localparam logic [7:0] BOOT_PAGE_LG   = 8'hff;
    localparam logic [8:0] FLASH_PAGES_SM = 9'd128;
    localparam logic [8:0] FLASH_PAGES_LG = 9'd256;

    // Window numbers (address bits 15..14).
    localparam logic [1:0] WIN_BOOT = 2'd0;
    localparam logic [1:0] WIN_ONE  = 2'd1;
    localparam logic [1:0] WIN_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  port;
        logic [7:0]  data;
        logic [15:0] address;
        logic        is_fetch;
    } zbm_in_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [22:0] phys_addr;
        logic        read_only;
        logic        out_of_range;
        logic        boot_done;
        logic        hi_ram_used;
    } zbm_out_t;

endpackage

// ===== src/z80_bank_memory_mapper.sv =====
// Top level of the Z80 bank memory mapper: input register, core, result register.
// Depends on zbm_pkg, zbm_core and z80_bank_memory_mapper_defines.svh.
//
//   Channel   Signals                         Moves
//   input     in_valid, in_stall, in_data     one command per transfer
//   output    out_valid, out_stall, out_data  one result per transfer
//   config    cfg_write, cfg_data             large_flash, one bit
//
// An item enters the input register at its transfer and crosses the single-pass
// core into the result register, from which its result is offered. One item a
// cycle is taken while the output side keeps up. A stall on a full result register
// holds it and, in the same cycle, stalls the input when the input register is full.
// Reset clears the bank registers, the mode and the flags at once, but sets the RAM
// bank register to its RAM select value; there is no clearing pass.
`include "z80_bank_memory_mapper_defines.svh"

module z80_bank_memory_mapper
    import zbm_pkg::*;
#(
    parameter int RAM_PAGES = RAM_PAGES_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_write,
    input  logic     cfg_data,
    input  logic     in_valid,
    output logic     in_stall,
    input  zbm_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output zbm_out_t out_data
);

    logic     in_valid_reg, in_valid_next;
    zbm_in_t  in_item_reg;
    logic     out_valid_reg, out_valid_next;
    zbm_out_t out_item_reg;
    zbm_out_t core_result;
    logic     advance;
    logic     step;

    // The result register takes a new item when it is empty or being drained.
    assign advance        = !out_valid_reg || !out_stall;
    assign step           = advance && in_valid_reg;
    assign in_stall       = in_valid_reg && !advance;
    assign in_valid_next  = in_stall ? 1'b1 : in_valid;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    zbm_core #(
        .RAM_PAGES (RAM_PAGES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (in_item_reg),
        .result    (core_result)
    );

    // Valid flags of both registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_data;
        if (step)
            out_item_reg <= core_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // An input item held by a stall is neither lost nor changed.
    `ZBM_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg), "held input item was lost or changed")

    // Boot end is sticky from one result to the next.
    `ZBM_ASSERT_NEXT(a_boot_sticky, clk, rst_n,
        out_valid && !out_stall && out_data.boot_done,
        !out_valid || out_data.boot_done, "boot_done fell without reset")

    // The high-RAM flag is sticky from one result to the next.
    `ZBM_ASSERT_NEXT(a_hi_ram_sticky, clk, rst_n,
        out_valid && !out_stall && out_data.hi_ram_used,
        !out_valid || out_data.hi_ram_used, "hi_ram_used fell without reset")

    // A port read result carries no translation.
    `ZBM_ASSERT_NOW(a_read_no_xlate, clk, rst_n,
        out_valid && out_data.read_data != 8'd0,
        out_data.phys_addr == 23'd0 && !out_data.read_only && !out_data.out_of_range,
        "port read result has translation fields set")

endmodule

// ===== src/zbm_core.sv =====
// Bank registers, boot and high-RAM flags, and the translation of one item.
// Depends on zbm_pkg.
module zbm_core
    import zbm_pkg::*;
#(
    parameter int RAM_PAGES = RAM_PAGES_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_write,
    input  logic     cfg_data,
    input  logic     step,
    input  zbm_in_t  item,
    output zbm_out_t result
);

    typedef struct packed {
        logic       ram;
        logic [7:0] idx;
    } zbm_page_t;

    logic       large_flash_reg;
    logic [7:0] bank_a_low_reg, bank_a_high_reg, bank_b_low_reg, bank_b_high_reg;
    logic [7:0] ram_bank_low_reg;
    logic       map_mode_reg, boot_ended_reg, hi_ram_flag_reg;

    logic [7:0] bank_a_low_next, bank_a_high_next, bank_b_low_next, bank_b_high_next;
    logic [7:0] ram_bank_low_next;
    logic       map_mode_next, boot_ended_next, hi_ram_flag_next;

    // Decode one bank byte pair into a page selection.
    function automatic zbm_page_t decode_bank(input logic [7:0] lo, input logic [7:0] hi,
                                              input logic lf);
        zbm_page_t p;
        p.ram = lo[7];
        p.idx = lo[7] ? {1'b0, lo[6:0]} : {hi[0] & lf, lo[6:0]};
        return p;
    endfunction

    // True if a page is a RAM page above 3.
    function automatic logic is_hi_ram(input zbm_page_t p);
        return p.ram && (p.idx[6:2] != 5'd0);
    endfunction

    zbm_page_t pg_a, pg_b, pg_r, pg_win;
    logic [1:0] win;
    logic [8:0] page_num;
    logic       boot_hit;

    // Next state and result for the item in the input register.
    always_comb
    begin
        bank_a_low_next   = bank_a_low_reg;
        bank_a_high_next  = bank_a_high_reg;
        bank_b_low_next   = bank_b_low_reg;
        bank_b_high_next  = bank_b_high_reg;
        ram_bank_low_next = ram_bank_low_reg;
        map_mode_next     = map_mode_reg;
        boot_ended_next   = boot_ended_reg;
        result            = '0;

        win      = item.address[15:14];
        boot_hit = item.is_fetch && (item.address[15:14] == WIN_ONE ||
                   (map_mode_reg && item.address[15:14] == WIN_TWO));

        case (item.command)
            CMD_PORT_WRITE:
            begin
                case (item.port)
                    PORT_RAM_BANK: ram_bank_low_next = item.data | RAM_SELECT;
                    PORT_BANK_A:   bank_a_low_next   = item.data;
                    PORT_BANK_B:   bank_b_low_next   = item.data;
                    PORT_BANK_A_H: bank_a_high_next  = item.data;
                    PORT_BANK_B_H: bank_b_high_next  = item.data;
                    default:       ;
                endcase
            end
            CMD_PORT_READ:
            begin
                if (item.port == PORT_RAM_BANK)
                    result.read_data = ram_bank_low_reg & ~RAM_SELECT;
                else if (item.port == PORT_BANK_B)
                    result.read_data = bank_b_low_reg;
                else
                    result.read_data = bank_a_low_reg;
            end
            CMD_SET_MODE:
            begin
                map_mode_next = (item.data != 8'd0);
            end
            default:
            begin
                // The boot check comes before this access is translated.
                if (boot_hit)
                    boot_ended_next = 1'b1;
            end
        endcase

        // Window translation for an access, from the state it sees.
        pg_a = decode_bank(bank_a_low_reg, bank_a_high_reg, large_flash_reg);
        pg_b = decode_bank(bank_b_low_reg, bank_b_high_reg, large_flash_reg);
        pg_r = decode_bank(ram_bank_low_reg, 8'd0, large_flash_reg);
        if (win == WIN_BOOT)
        begin
            pg_win.ram = 1'b0;
            pg_win.idx = boot_ended_next ? 8'd0
                       : (large_flash_reg ? BOOT_PAGE_LG : BOOT_PAGE_SM);
        end
        else if (!map_mode_reg)
            pg_win = (win == WIN_ONE) ? pg_a : ((win == WIN_TWO) ? pg_b : pg_r);
        else if (win == WIN_ONE)
            pg_win = '{ram: pg_a.ram, idx: {pg_a.idx[7:1], 1'b0}};
        else if (win == WIN_TWO)
            pg_win = '{ram: pg_a.ram, idx: {pg_a.idx[7:1], 1'b1}};
        else
            pg_win = pg_b;

        if (pg_win.ram)
            page_num = (large_flash_reg ? FLASH_PAGES_LG : FLASH_PAGES_SM)
                     + {1'b0, pg_win.idx};
        else
            page_num = {1'b0, pg_win.idx};

        if (item.command == CMD_ACCESS)
        begin
            result.phys_addr    = {page_num, item.address[13:0]};
            result.read_only    = !pg_win.ram;
            result.out_of_range = pg_win.ram && (pg_win.idx >= 8'(RAM_PAGES));
        end

        // The high-RAM flag looks at windows 1 to 3 as mapped after this item.
        hi_ram_flag_next = hi_ram_flag_reg
            || is_hi_ram(decode_bank(bank_a_low_next, bank_a_high_next, large_flash_reg))
            || is_hi_ram(decode_bank(bank_b_low_next, bank_b_high_next, large_flash_reg))
            || (!map_mode_next
                && is_hi_ram(decode_bank(ram_bank_low_next, 8'd0, large_flash_reg)));

        result.boot_done   = boot_ended_next;
        result.hi_ram_used = hi_ram_flag_next;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            large_flash_reg <= 1'b0;
        else if (cfg_write)
            large_flash_reg <= cfg_data;
    end

    // Mapper state advances when an item moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_a_low_reg   <= 8'd0;
            bank_a_high_reg  <= 8'd0;
            bank_b_low_reg   <= 8'd0;
            bank_b_high_reg  <= 8'd0;
            ram_bank_low_reg <= RAM_SELECT;
            map_mode_reg     <= 1'b0;
            boot_ended_reg   <= 1'b0;
            hi_ram_flag_reg  <= 1'b0;
        end
        else if (step)
        begin
            bank_a_low_reg   <= bank_a_low_next;
            bank_a_high_reg  <= bank_a_high_next;
            bank_b_low_reg   <= bank_b_low_next;
            bank_b_high_reg  <= bank_b_high_next;
            ram_bank_low_reg <= ram_bank_low_next;
            map_mode_reg     <= map_mode_next;
            boot_ended_reg   <= boot_ended_next;
            hi_ram_flag_reg  <= hi_ram_flag_next;
        end
    end

endmodule
